### rtl/rtrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the read transfer retransmit controller.
// No dependencies; imported by the controller top level.

package rtrc_pkg;

	// Full block payload; a shorter block ends the transfer
	localparam int unsigned BLOCK_BYTES = 512;
	localparam int unsigned LEN_W       = 10;

	localparam logic [15:0] ACK_OPCODE  = 16'd4;

	// Register reset values
	localparam logic [15:0] RESET_TIMEOUT = 16'd50;
	localparam logic [15:0] RESET_TMIN    = 16'd50;
	localparam logic [15:0] RESET_TMAX    = 16'd10000;
	localparam logic [3:0]  RESET_RETRIES = 4'd8;

	// floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for x below 2^34
	localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
	localparam int unsigned DIV10_SHIFT = 35;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_READY = 2'd1,
		OP_PKT   = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_INIT_TIMEOUT = 2'd0,
		CFG_TIMEOUT_MIN  = 2'd1,
		CFG_TIMEOUT_MAX  = 2'd2,
		CFG_MAX_RETRIES  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_SEND    = 3'd1,
		ACT_RESEND  = 3'd2,
		ACT_WANT    = 3'd3,
		ACT_DONE    = 3'd4,
		ACT_UNKNOWN = 3'd5,
		ACT_GIVE_UP = 3'd6
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [15:0]        block_number;
		logic [LEN_W-1:0]   send_len;
		logic [15:0]        timeout_ms;
		logic [3:0]         retry_count;
	} result_t;

endpackage

`default_nettype wire

### rtl/read_transfer_retransmit_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the read transfer retransmit controller (stop-and-wait sender).
// Depends on rtrc_pkg for codes, constants and the result word type.

// Sender side of a stop-and-wait block transfer with an adaptive retransmit
// timeout. Each input word is one event: start, next block ready, packet
// received, or a one millisecond tick. Every event produces exactly one result
// word carrying the action taken plus the block number, block length, timeout
// and retry count in force after the event. At the accepting edge the transfer
// state updates and the result word lands in the output or skid register, so
// the block sustains one word per cycle while the output side is not stalled.
// The critical path is the round-trip average update on an acknowledgement: a
// 9x-plus-sample add feeding a 29 x 32 reciprocal multiply for the divide by
// ten, then the timeout clamp. A two-entry output stage (output register plus
// skid register) lets the input side accept one more word while the
// output side is stalled; in_stall is a plain register output. Configuration
// writes are taken any cycle and should only be issued while the block is idle.

module read_transfer_retransmit_controller (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration write port
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [15:0]                 cfg_data,
	// event input channel
	input  wire logic                        in_valid,
	output      logic                        in_stall,
	input  wire logic [1:0]                  op,
	input  wire logic [15:0]                 peer_port,
	input  wire logic [rtrc_pkg::LEN_W-1:0]  block_len,
	input  wire logic [15:0]                 pkt_opcode,
	input  wire logic [15:0]                 pkt_block,
	input  wire logic [15:0]                 src_port,
	// result output channel
	output      logic                        out_valid,
	input  wire logic                        out_stall,
	output      logic [2:0]                  action,
	output      logic [15:0]                 block_number,
	output      logic [rtrc_pkg::LEN_W-1:0]  send_len,
	output      logic [15:0]                 timeout_ms,
	output      logic [3:0]                  retry_count
);
	import rtrc_pkg::*;

	localparam logic [LEN_W-1:0] BLOCK_FULL = LEN_W'(BLOCK_BYTES);

	// Configuration registers
	logic [15:0] init_timeout_q, tmin_q, tmax_q;
	logic [3:0]  max_retries_q;

	// Transfer state
	logic [15:0]      partner_port_q, cur_block_q, timeout_q;
	logic [15:0]      resend_elapsed_q, rtt_elapsed_q;
	logic [LEN_W-1:0] cur_len_q;
	logic [23:0]      rtt_avg_q;
	logic [3:0]       retries_q;
	logic             awaiting_q, last_sent_q, active_q, sample_bad_q;

	// Next-state values
	logic [15:0]      partner_port_d, cur_block_d, timeout_d;
	logic [15:0]      resend_elapsed_d, rtt_elapsed_d;
	logic [LEN_W-1:0] cur_len_d, blen_sat;
	logic [23:0]      rtt_avg_d;
	logic [3:0]       retries_d, retries_inc;
	logic             awaiting_d, last_sent_d, active_d, sample_bad_d;
	action_t          act_d;

	// Average update datapath
	logic [28:0] fold_acc;
	logic [60:0] fold_prod;
	logic [23:0] fold_avg;
	logic [15:0] fold_timeout, resend_timeout;

	// Output stage
	result_t res_d, out_q, skid_q;
	logic    out_valid_q, skid_valid_q, in_acc, out_take;

	function automatic logic [15:0] clamp_ms(input logic [16:0] t,
	                                         input logic [15:0] lo,
	                                         input logic [15:0] hi);
		logic [15:0] r;
		if (t < {1'b0, lo})
			r = lo;
		else if (t > {1'b0, hi})
			r = hi;
		else
			r = t[15:0];
		return r;
	endfunction

	assign in_acc   = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;
	assign in_stall = skid_valid_q;

	// Config write port: no read-back, every index decodes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_timeout_q <= RESET_TIMEOUT;
			tmin_q         <= RESET_TMIN;
			tmax_q         <= RESET_TMAX;
			max_retries_q  <= RESET_RETRIES;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_INIT_TIMEOUT: init_timeout_q <= cfg_data;
				CFG_TIMEOUT_MIN:  tmin_q         <= cfg_data;
				CFG_TIMEOUT_MAX:  tmax_q         <= cfg_data;
				CFG_MAX_RETRIES:  max_retries_q  <= cfg_data[3:0];
				default:          ;
			endcase
		end
	end

	// Round-trip average: (9*avg + sample*256 + 5) / 10, divide by reciprocal
	assign fold_acc     = 29'({rtt_avg_q, 3'b000}) + 29'(rtt_avg_q)
	                    + 29'({rtt_elapsed_q, 8'h00}) + 29'd5;
	assign fold_prod    = 61'(fold_acc) * 61'(DIV10_MUL);
	assign fold_avg     = fold_prod[DIV10_SHIFT +: 24];
	// Timeout is twice the average in whole ms
	assign fold_timeout = clamp_ms(fold_avg[23:7], tmin_q, tmax_q);
	// Resend doubles the timeout
	assign resend_timeout = clamp_ms({timeout_q, 1'b0}, tmin_q, tmax_q);

	assign blen_sat    = (block_len > BLOCK_FULL) ? BLOCK_FULL : block_len;
	assign retries_inc = retries_q + 4'd1;

	// Event decode
	always_comb begin
		partner_port_d   = partner_port_q;
		cur_block_d      = cur_block_q;
		cur_len_d        = cur_len_q;
		awaiting_d       = awaiting_q;
		last_sent_d      = last_sent_q;
		active_d         = active_q;
		sample_bad_d     = sample_bad_q;
		rtt_avg_d        = rtt_avg_q;
		timeout_d        = timeout_q;
		resend_elapsed_d = resend_elapsed_q;
		rtt_elapsed_d    = rtt_elapsed_q;
		retries_d        = retries_q;
		act_d            = ACT_NONE;

		unique case (op_t'(op))
			OP_START: begin
				// Restart from block 0, initial timeout taken unclamped
				partner_port_d   = peer_port;
				cur_block_d      = '0;
				cur_len_d        = '0;
				awaiting_d       = 1'b0;
				last_sent_d      = 1'b0;
				active_d         = 1'b1;
				sample_bad_d     = 1'b0;
				rtt_avg_d        = {init_timeout_q, 8'h00};
				timeout_d        = init_timeout_q;
				resend_elapsed_d = '0;
				rtt_elapsed_d    = '0;
				retries_d        = '0;
				act_d            = ACT_WANT;
			end
			OP_READY: begin
				if (active_q && !awaiting_q) begin
					cur_len_d        = blen_sat;
					last_sent_d      = blen_sat < BLOCK_FULL;
					cur_block_d      = cur_block_q + 16'd1;
					awaiting_d       = 1'b1;
					sample_bad_d     = 1'b0;
					resend_elapsed_d = '0;
					rtt_elapsed_d    = '0;
					retries_d        = '0;
					act_d            = ACT_SEND;
				end
			end
			OP_PKT: begin
				if (active_q) begin
					if (src_port != partner_port_q) begin
						// Foreign port: report, keep the bound port
						act_d = ACT_UNKNOWN;
					end else if (pkt_opcode == ACK_OPCODE && awaiting_q &&
					             pkt_block == cur_block_q) begin
						// Fold the sample only if the block was never resent
						if (!sample_bad_q) begin
							rtt_avg_d = fold_avg;
							timeout_d = fold_timeout;
						end
						awaiting_d = 1'b0;
						if (last_sent_q) begin
							active_d = 1'b0;
							act_d    = ACT_DONE;
						end else begin
							act_d = ACT_WANT;
						end
					end
				end
			end
			OP_TICK: begin
				if (active_q && awaiting_q) begin
					if (rtt_elapsed_q != 16'hFFFF)
						rtt_elapsed_d = rtt_elapsed_q + 16'd1;
					if (resend_elapsed_q >= timeout_q) begin
						resend_elapsed_d = '0;
						sample_bad_d     = 1'b1;
						retries_d        = retries_inc;
						timeout_d        = resend_timeout;
						if (retries_inc >= max_retries_q) begin
							active_d   = 1'b0;
							awaiting_d = 1'b0;
							act_d      = ACT_GIVE_UP;
						end else begin
							act_d = ACT_RESEND;
						end
					end else begin
						resend_elapsed_d = resend_elapsed_q + 16'd1;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res_d.action       = act_d;
		res_d.block_number = cur_block_d;
		res_d.send_len     = cur_len_d;
		res_d.timeout_ms   = timeout_d;
		res_d.retry_count  = retries_d;
	end

	// Advance transfer state on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partner_port_q   <= '0;
			cur_block_q      <= '0;
			cur_len_q        <= '0;
			awaiting_q       <= 1'b0;
			last_sent_q      <= 1'b0;
			active_q         <= 1'b0;
			sample_bad_q     <= 1'b0;
			rtt_avg_q        <= {RESET_TIMEOUT, 8'h00};
			timeout_q        <= RESET_TIMEOUT;
			resend_elapsed_q <= '0;
			rtt_elapsed_q    <= '0;
			retries_q        <= '0;
		end else if (in_acc) begin
			partner_port_q   <= partner_port_d;
			cur_block_q      <= cur_block_d;
			cur_len_q        <= cur_len_d;
			awaiting_q       <= awaiting_d;
			last_sent_q      <= last_sent_d;
			active_q         <= active_d;
			sample_bad_q     <= sample_bad_d;
			rtt_avg_q        <= rtt_avg_d;
			timeout_q        <= timeout_d;
			resend_elapsed_q <= resend_elapsed_d;
			rtt_elapsed_q    <= rtt_elapsed_d;
			retries_q        <= retries_d;
		end
	end

	// Output register plus skid register; skid drains first to keep order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (in_acc)
				out_q <= res_d;
		end else if (in_acc) begin
			skid_q <= res_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = out_q.action;
	assign block_number = out_q.block_number;
	assign send_len     = out_q.send_len;
	assign timeout_ms   = out_q.timeout_ms;
	assign retry_count  = out_q.retry_count;

endmodule

`default_nettype wire

### sim/tb_rtrc_checker.sv
`timescale 1ns / 1ps
// Checker for the read transfer retransmit controller: watches the config port
// and both word channels, predicts every result word and compares it.
// Depends on rtrc_pkg for the op, register and action codes and result_t.

module tb_rtrc_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [15:0]                 cfg_data,
	input  wire logic                        in_valid,
	input  wire logic                        in_stall,
	input  wire logic [1:0]                  op,
	input  wire logic [15:0]                 peer_port,
	input  wire logic [rtrc_pkg::LEN_W-1:0]  block_len,
	input  wire logic [15:0]                 pkt_opcode,
	input  wire logic [15:0]                 pkt_block,
	input  wire logic [15:0]                 src_port,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic [2:0]                  action,
	input  wire logic [15:0]                 block_number,
	input  wire logic [rtrc_pkg::LEN_W-1:0]  send_len,
	input  wire logic [15:0]                 timeout_ms,
	input  wire logic [3:0]                  retry_count,
	output int                               words_waiting,
	output int                               fail_count
);
	import rtrc_pkg::*;

	logic [15:0]      cfg_init, cfg_tmin, cfg_tmax;
	logic [3:0]       cfg_retries;

	logic [15:0]      partner, cur_block;
	logic [LEN_W-1:0] cur_len;
	logic             awaiting, last_sent, running, sample_bad;
	logic [23:0]      rtt_avg;
	logic [15:0]      tmo, resend_ms, rtt_ms;
	logic [3:0]       tries;

	result_t          expected_results[$];

	initial begin
		fail_count = 0;
		words_waiting = 0;
	end

	function automatic logic [15:0] clamp_ms(input logic [31:0] t);
		if (t < {16'd0, cfg_tmin}) return cfg_tmin;
		if (t > {16'd0, cfg_tmax}) return cfg_tmax;
		return t[15:0];
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Advance the sender by one event word and return the result it causes
	task automatic step_sender(input op_t o, input logic [15:0] peer,
			input logic [LEN_W-1:0] blen, input logic [15:0] opc,
			input logic [15:0] blk, input logic [15:0] sport, output result_t r);
		logic [31:0]      acc;
		logic [LEN_W-1:0] len;
		action_t          act;
		act = ACT_NONE;
		case (o)
			OP_START: begin
				partner = peer;
				cur_block = '0;
				cur_len = '0;
				awaiting = 1'b0;
				last_sent = 1'b0;
				running = 1'b1;
				sample_bad = 1'b0;
				rtt_avg = {cfg_init, 8'd0};
				tmo = cfg_init;
				resend_ms = '0;
				rtt_ms = '0;
				tries = '0;
				act = ACT_WANT;
			end
			OP_READY: begin
				if (running && !awaiting) begin
					len = (blen > BLOCK_BYTES) ? LEN_W'(BLOCK_BYTES) : blen;
					cur_len = len;
					last_sent = (len < BLOCK_BYTES);
					cur_block = cur_block + 16'd1;
					awaiting = 1'b1;
					sample_bad = 1'b0;
					resend_ms = '0;
					rtt_ms = '0;
					tries = '0;
					act = ACT_SEND;
				end
			end
			OP_PKT: begin
				if (running) begin
					if (sport != partner) begin
						act = ACT_UNKNOWN;
					end else if (opc == ACK_OPCODE && awaiting && blk == cur_block) begin
						if (!sample_bad) begin
							acc = 9 * {8'd0, rtt_avg} + {8'd0, rtt_ms, 8'd0} + 32'd5;
							rtt_avg = 24'(acc / 10);
							tmo = clamp_ms({15'd0, rtt_avg[23:7]});
						end
						awaiting = 1'b0;
						if (last_sent) begin
							running = 1'b0;
							act = ACT_DONE;
						end else begin
							act = ACT_WANT;
						end
					end
				end
			end
			default: begin
				if (running && awaiting) begin
					if (rtt_ms != 16'hFFFF) rtt_ms = rtt_ms + 16'd1;
					if (resend_ms >= tmo) begin
						resend_ms = '0;
						sample_bad = 1'b1;
						tries = tries + 4'd1;
						tmo = clamp_ms({15'd0, tmo, 1'b0});
						if (tries >= cfg_retries) begin
							running = 1'b0;
							awaiting = 1'b0;
							act = ACT_GIVE_UP;
						end else begin
							act = ACT_RESEND;
						end
					end else begin
						resend_ms = resend_ms + 16'd1;
					end
				end
			end
		endcase
		r.action = act;
		r.block_number = cur_block;
		r.send_len = cur_len;
		r.timeout_ms = tmo;
		r.retry_count = tries;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			cfg_init = RESET_TIMEOUT;
			cfg_tmin = RESET_TMIN;
			cfg_tmax = RESET_TMAX;
			cfg_retries = RESET_RETRIES;
			partner = '0;
			cur_block = '0;
			cur_len = '0;
			awaiting = 1'b0;
			last_sent = 1'b0;
			running = 1'b0;
			sample_bad = 1'b0;
			rtt_avg = {RESET_TIMEOUT, 8'd0};
			tmo = RESET_TIMEOUT;
			resend_ms = '0;
			rtt_ms = '0;
			tries = '0;
			expected_results.delete();
		end else begin
			// results leave before new words enter: an output word can never
			// belong to the word accepted at the same edge
			if (out_valid && !out_stall) begin
				got.action = action_t'(action);
				got.block_number = block_number;
				got.send_len = send_len;
				got.timeout_ms = timeout_ms;
				got.retry_count = retry_count;
				if (expected_results.size() == 0) begin
					$error("result word with no expectation: action %0d", action);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("action", want.action, got.action);
					check_field("block_number", want.block_number, got.block_number);
					check_field("send_len", want.send_len, got.send_len);
					check_field("timeout_ms", want.timeout_ms, got.timeout_ms);
					check_field("retry_count", want.retry_count, got.retry_count);
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_INIT_TIMEOUT: cfg_init = cfg_data;
					CFG_TIMEOUT_MIN:  cfg_tmin = cfg_data;
					CFG_TIMEOUT_MAX:  cfg_tmax = cfg_data;
					default:          cfg_retries = cfg_data[3:0];
				endcase
			end
			if (in_valid && !in_stall) begin
				step_sender(op_t'(op), peer_port, block_len, pkt_opcode, pkt_block,
					src_port, want);
				// append at the tail so results stay in order
				expected_results.insert(expected_results.size(), want);
			end
		end
		words_waiting = expected_results.size();
	end

endmodule

### sim/tb_read_transfer_retransmit_controller.sv
`timescale 1ns / 1ps
// Testbench top for the read transfer retransmit controller: clock, reset,
// event and config stimulus, output stall, verdict. Needs rtrc_pkg and tb_rtrc_checker.

module tb_read_transfer_retransmit_controller;
	import rtrc_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;

	logic                cfg_we = 1'b0;
	cfg_reg_t            cfg_index = CFG_INIT_TIMEOUT;
	logic [15:0]         cfg_data = '0;

	logic                in_valid = 1'b0;
	logic                in_stall;
	op_t                 op = OP_TICK;
	logic [15:0]         peer_port = '0;
	logic [LEN_W-1:0]    block_len = '0;
	logic [15:0]         pkt_opcode = '0;
	logic [15:0]         pkt_block = '0;
	logic [15:0]         src_port = '0;

	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [2:0]          action;
	logic [15:0]         block_number;
	logic [LEN_W-1:0]    send_len;
	logic [15:0]         timeout_ms;
	logic [3:0]          retry_count;

	int                  words_waiting;
	int                  fail_count;

	// calm turns off idling on both sides; the final phase runs calm throughout
	bit                  calm = 1'b0;
	int                  stall_left = 0;
	int                  sent_words = 0;

	read_transfer_retransmit_controller u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.peer_port    (peer_port),
		.block_len    (block_len),
		.pkt_opcode   (pkt_opcode),
		.pkt_block    (pkt_block),
		.src_port     (src_port),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.block_number (block_number),
		.send_len     (send_len),
		.timeout_ms   (timeout_ms),
		.retry_count  (retry_count)
	);

	tb_rtrc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.peer_port    (peer_port),
		.block_len    (block_len),
		.pkt_opcode   (pkt_opcode),
		.pkt_block    (pkt_block),
		.src_port     (src_port),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.block_number (block_number),
		.send_len     (send_len),
		.timeout_ms   (timeout_ms),
		.retry_count  (retry_count),
		.words_waiting(words_waiting),
		.fail_count   (fail_count)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Output stall in random bursts; one assignment per edge
	always @(negedge clk) begin
		if (calm) begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Hard stop well past the slowest correct run
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [15:0] r16();
		return 16'($urandom);
	endfunction

	function automatic logic [LEN_W-1:0] r10();
		return LEN_W'($urandom);
	endfunction

	// Offer one event word and hold it until accepted. Entered and left at a
	// falling edge; valid is left high so back-to-back words never drop it.
	task automatic put_word(input op_t o, input logic [15:0] peer,
			input logic [LEN_W-1:0] len, input logic [15:0] opc,
			input logic [15:0] blk, input logic [15:0] sport);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		op <= o;
		peer_port <= peer;
		block_len <= len;
		pkt_opcode <= opc;
		pkt_block <= blk;
		src_port <= sport;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_words++;
		@(negedge clk);
	endtask

	// Hold off input, then wait until every predicted word has come back
	// plus a short pause for the output stage to settle
	task automatic drain();
		in_valid <= 1'b0;
		while (words_waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
	endtask

	task automatic configure(input logic [15:0] init_ms, input logic [15:0] tmin,
			input logic [15:0] tmax, input logic [3:0] retries);
		put_reg(CFG_INIT_TIMEOUT, init_ms);
		put_reg(CFG_TIMEOUT_MIN, tmin);
		put_reg(CFG_TIMEOUT_MAX, tmax);
		put_reg(CFG_MAX_RETRIES, {12'($urandom), retries});
		cfg_we <= 1'b0;
	endtask

	// A misplaced word in the middle of a transfer: foreign port, non-ack,
	// ack for the wrong block, or a ready while an ack is still pending
	task automatic stray_word(input logic [15:0] peer, input logic [15:0] blk);
		case ($urandom_range(0, 3))
			0: put_word(OP_PKT, r16(), r10(), ACK_OPCODE, blk,
				peer ^ 16'($urandom_range(1, 65535)));
			1: put_word(OP_PKT, r16(), r10(), ACK_OPCODE ^ 16'($urandom_range(1, 65535)),
				blk, peer);
			2: put_word(OP_PKT, r16(), r10(), ACK_OPCODE,
				blk ^ 16'($urandom_range(1, 65535)), peer);
			default: put_word(OP_READY, r16(), r10(), r16(), r16(), r16());
		endcase
	endtask

	// One well-formed transfer: start, then blocks each followed by some ticks
	// and the matching ack. Tick counts past the timeout force resends and
	// sometimes a give-up; the next start brings things back in step.
	task automatic run_transfer(input int tick_hi);
		logic [15:0]      peer;
		logic [15:0]      blk;
		logic [LEN_W-1:0] len;
		int               n_blocks;
		peer = r16();
		blk = '0;
		put_word(OP_START, peer, r10(), r16(), r16(), r16());
		n_blocks = $urandom_range(1, 6);
		for (int i = 0; i < n_blocks; i++) begin
			len = ($urandom_range(0, 9) < 7) ? LEN_W'(BLOCK_BYTES) : r10();
			put_word(OP_READY, r16(), len, r16(), r16(), r16());
			blk = blk + 16'd1;
			repeat ($urandom_range(0, tick_hi)) begin
				if ($urandom_range(0, 19) == 0) stray_word(peer, blk);
				put_word(OP_TICK, r16(), r10(), r16(), r16(), r16());
			end
			put_word(OP_PKT, r16(), r10(), ACK_OPCODE, blk, peer);
			if (len < BLOCK_BYTES) break;
		end
	endtask

	// One configuration setting and a stretch of random traffic under it
	task automatic run_phase(input logic [15:0] init_ms, input logic [15:0] tmin,
			input logic [15:0] tmax, input logic [3:0] retries, input int tick_hi,
			input int n_words, input bit quiet);
		int stop_at;
		drain();
		configure(init_ms, tmin, tmax, retries);
		calm = quiet;
		stop_at = sent_words + n_words;
		while (sent_words < stop_at) begin
			if (!quiet) calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) == 0) begin
				// pure noise: any op, any field values
				repeat ($urandom_range(1, 6))
					put_word(op_t'($urandom_range(0, 3)), r16(), r10(), r16(), r16(), r16());
			end else begin
				run_transfer(tick_hi);
			end
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at the reset configuration.
		// Everything is ignored while no transfer is running.
		put_word(OP_READY, r16(), 10'd512, r16(), r16(), r16());
		put_word(OP_PKT, r16(), r10(), ACK_OPCODE, 16'd0, 16'd0);
		put_word(OP_TICK, r16(), r10(), r16(), r16(), r16());
		// Transfer to the top port; an overlong block saturates to a full one
		put_word(OP_START, 16'hFFFF, r10(), r16(), r16(), r16());
		put_word(OP_READY, r16(), 10'h3FF, r16(), r16(), r16());
		put_word(OP_READY, r16(), 10'd0, r16(), r16(), r16());
		put_word(OP_PKT, r16(), r10(), ACK_OPCODE, 16'd1, 16'd0);
		put_word(OP_PKT, r16(), r10(), 16'd3, 16'd1, 16'hFFFF);
		put_word(OP_PKT, r16(), r10(), ACK_OPCODE, 16'hFFFF, 16'hFFFF);
		repeat (3) put_word(OP_TICK, r16(), r10(), r16(), r16(), r16());
		put_word(OP_PKT, r16(), r10(), ACK_OPCODE, 16'd1, 16'hFFFF);
		// Duplicate ack with nothing pending
		put_word(OP_PKT, r16(), r10(), ACK_OPCODE, 16'd1, 16'hFFFF);
		// Short block ends the transfer
		put_word(OP_READY, r16(), 10'd511, r16(), r16(), r16());
		put_word(OP_TICK, r16(), r10(), r16(), r16(), r16());
		put_word(OP_PKT, r16(), r10(), ACK_OPCODE, 16'd2, 16'hFFFF);
		put_word(OP_PKT, r16(), r10(), ACK_OPCODE, 16'd3, 16'hFFFF);
		// Port zero, then a restart while a block is in flight
		put_word(OP_START, 16'd0, r10(), r16(), r16(), r16());
		put_word(OP_READY, r16(), 10'd1, r16(), r16(), r16());
		put_word(OP_START, 16'h1234, r10(), r16(), r16(), r16());
		put_word(OP_TICK, r16(), r10(), r16(), r16(), r16());
		put_word(OP_PKT, r16(), r10(), 16'hFFFF, 16'h0000, 16'h1234);

		// Random phases, extremes of every register among them
		run_phase(RESET_TIMEOUT, RESET_TMIN, RESET_TMAX, RESET_RETRIES, 70, 220, 1'b0);
		run_phase(16'd3, 16'd1, 16'd40, 4'd15, 30, 200, 1'b0);
		// zero start timeout and a retry limit of zero
		run_phase(16'd0, 16'd2, 16'd6, 4'd0, 12, 180, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd1, 20, 120, 1'b0);
		// lower clamp above the upper one
		run_phase(16'd10, 16'd20, 16'd5, 4'd3, 50, 200, 1'b0);
		run_phase(16'd1, 16'd1, 16'hFFFF, 4'd4, 25, 200, 1'b0);
		// last stretch at full rate, no idling on either side
		run_phase(16'd5, 16'd1, 16'd1, 4'd2, 8, 220, 1'b1);

		drain();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
